/* sv/pms_pkg.sv */
// Shared constants, codes and types of the partitioned multi-stack block.
package pms_pkg;

	localparam int MEM_DEPTH  = 64;
	localparam int MAX_STACKS = 10;

	localparam int WORD_W  = 32;
	localparam int KIND_W  = 2;
	localparam int SN_W    = 4;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 4;
	localparam int TW_W    = 7;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);
	localparam int FILL_W  = $clog2(MEM_DEPTH + 1);
	localparam int PROD_W  = SN_W + FILL_W;
	localparam int SIDX_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int STEP_W  = $clog2(TW_W);

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_LIST = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_PUSHED    = 3'd0,
		STAT_OVERFLOW  = 3'd1,
		STAT_POPPED    = 3'd2,
		STAT_UNDERFLOW = 3'd3,
		STAT_EMPTY     = 3'd4,
		STAT_LISTED    = 3'd5,
		STAT_BAD       = 3'd6
	} status_t;

	typedef enum logic [0:0] {
		REG_STACK_COUNT = 1'b0,
		REG_TOTAL_WORDS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LIST,
		S_DIV
	} state_t;

	typedef struct packed {
		logic             start;
		logic [TW_W-1:0]  num;
		logic [CNT_W-1:0] den;
	} div_req_t;

endpackage

/* sv/pms_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module pms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* sv/pms_seg_div.sv */
// Bit-serial restoring divider that works out the segment length per stack.
module pms_seg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pms_pkg::div_req_t          req,
	output logic                       done,
	output logic [pms_pkg::TW_W-1:0]   quot
);
	import pms_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TW_W-1:0]   num_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	// One quotient bit per cycle; the quotient shifts into the dividend register.
	assign trial = {rem_q, num_q[TW_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(TW_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[TW_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

/* sv/partitioned_multi_stack_core.sv */
// Top level of the partitioned multi-stack: stacks in one shared RAM, APB setup.
// Push, pop, bad stack, empty: result strobe registered from the execute state; busy is low with it.
// Display of n entries: one word per cycle from the list state; busy until the last word is read.
// Each word comes from one RAM port access per cycle; results cannot be stalled.
// A register write empties all stacks and repartitions: busy until the divider is done.
// Reset empties all stacks; stored words are undefined until pushed.
module partitioned_multi_stack_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pms_pkg::PADDR_W-1:0]         paddr,
	input  logic [pms_pkg::PDATA_W-1:0]         pwdata,
	output logic [pms_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [pms_pkg::KIND_W-1:0]          kind,
	input  logic [pms_pkg::SN_W-1:0]            stack_index,
	input  logic signed [pms_pkg::WORD_W-1:0]   push_value,
	output logic                                strobe,
	output logic [pms_pkg::STAT_W-1:0]          status,
	output logic signed [pms_pkg::WORD_W-1:0]   data_word,
	output logic                                last
);
	import pms_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [TW_W-1:0]   total_q;
	logic [FILL_W-1:0] seg_q;
	logic [FILL_W-1:0] fill_q [MAX_STACKS];

	kind_t             kind_q;
	logic [SN_W-1:0]   sn_q;
	logic [WORD_W-1:0] val_q;

	logic [ADDR_W-1:0] base_q, base_d;
	logic [FILL_W-1:0] idx_q, idx_d;
	logic [FILL_W-1:0] lcnt_q, lcnt_d;

	logic              stb_q, stb_d;
	status_t           st_q, st_d;
	logic              last_q, last_d;
	logic              rd_q, rd_d;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	logic [CNT_W-1:0]  count_nx, count_eff;
	logic [TW_W-1:0]   total_nx, total_eff;
	div_req_t          div_req;
	logic              div_done;
	logic [TW_W-1:0]   div_quot;

	logic [SIDX_W-1:0] sidx;
	logic [FILL_W-1:0] fill_raw, fill_eff;
	logic [PROD_W-1:0] base_full, top_sum;
	logic [CNT_W-1:0]  live_eff;
	logic              bad;
	logic              fill_we;
	logic [FILL_W-1:0] fill_wdata;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [WORD_W-1:0] ram_rdata;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_STACK_COUNT: prdata = PDATA_W'(count_q);
			REG_TOTAL_WORDS: prdata = PDATA_W'(total_q);
		endcase
	end

	// Values the registers hold after this cycle, clamped for the divider.
	always_comb begin
		count_nx = count_q;
		total_nx = total_q;
		if (cfg_wr) begin
			unique case (cfg_idx)
				REG_STACK_COUNT: count_nx = pwdata[CNT_W-1:0];
				REG_TOTAL_WORDS: total_nx = pwdata[TW_W-1:0];
			endcase
		end
		count_eff = count_nx;
		if (count_nx == '0) begin
			count_eff = CNT_W'(1);
		end else if (int'(count_nx) > MAX_STACKS) begin
			count_eff = CNT_W'(MAX_STACKS);
		end
		total_eff = total_nx;
		if (total_nx == '0) begin
			total_eff = TW_W'(1);
		end else if (int'(total_nx) > MEM_DEPTH) begin
			total_eff = TW_W'(MEM_DEPTH);
		end
	end

	assign div_req.start = cfg_wr;
	assign div_req.num   = total_eff;
	assign div_req.den   = count_eff;

	pms_seg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Effective stack count for the bad-stack check.
	always_comb begin
		live_eff = count_q;
		if (count_q == '0) begin
			live_eff = CNT_W'(1);
		end else if (int'(count_q) > MAX_STACKS) begin
			live_eff = CNT_W'(MAX_STACKS);
		end
	end

	assign bad       = (sn_q >= live_eff) || (int'(sn_q) >= MAX_STACKS);
	assign sidx      = sn_q[SIDX_W-1:0];
	assign fill_raw  = bad ? '0 : fill_q[sidx];
	assign fill_eff  = (fill_raw > seg_q) ? seg_q : fill_raw;
	assign base_full = PROD_W'(sn_q) * PROD_W'(seg_q);
	assign top_sum   = base_full + PROD_W'(fill_eff);

	always_comb begin
		state_d    = state_q;
		base_d     = base_q;
		idx_d      = idx_q;
		lcnt_d     = lcnt_q;
		stb_d      = 1'b0;
		st_d       = STAT_PUSHED;
		last_d     = 1'b1;
		rd_d       = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = ADDR_W'(base_q + ADDR_W'(idx_q));
		fill_we    = 1'b0;
		fill_wdata = fill_eff;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (kind_q != KIND_NONE && bad) begin
					stb_d = 1'b1;
					st_d  = STAT_BAD;
				end else begin
					unique case (kind_q)
						KIND_PUSH: begin
							stb_d = 1'b1;
							if (fill_eff >= seg_q || int'(top_sum) >= MEM_DEPTH) begin
								st_d = STAT_OVERFLOW;
							end else begin
								st_d       = STAT_PUSHED;
								ram_we     = 1'b1;
								ram_addr   = top_sum[ADDR_W-1:0];
								fill_we    = 1'b1;
								fill_wdata = fill_eff + 1'b1;
							end
						end
						KIND_POP: begin
							stb_d = 1'b1;
							if (fill_eff == '0) begin
								st_d = STAT_UNDERFLOW;
							end else begin
								st_d       = STAT_POPPED;
								rd_d       = 1'b1;
								ram_addr   = ADDR_W'(top_sum - 1'b1);
								fill_we    = 1'b1;
								fill_wdata = fill_eff - 1'b1;
							end
						end
						KIND_LIST: begin
							if (fill_eff == '0) begin
								stb_d = 1'b1;
								st_d  = STAT_EMPTY;
							end else begin
								state_d = S_LIST;
								base_d  = base_full[ADDR_W-1:0];
								idx_d   = '0;
								lcnt_d  = fill_eff;
							end
						end
						KIND_NONE: begin
						end
					endcase
				end
			end
			S_LIST: begin
				// One word read per cycle; its strobe follows with the read data.
				stb_d  = 1'b1;
				st_d   = STAT_LISTED;
				rd_d   = 1'b1;
				last_d = (idx_q + 1'b1 == lcnt_q);
				idx_d  = idx_q + 1'b1;
				if (last_d) begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_IDLE;
				end
			end
		endcase

		if (cfg_wr) begin
			state_d = S_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNT_W'(1);
			total_q <= TW_W'(64);
			seg_q   <= FILL_W'(MEM_DEPTH);
			stb_q   <= 1'b0;
			for (int i = 0; i < MAX_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			count_q <= count_nx;
			total_q <= total_nx;
			stb_q   <= stb_d;
			if (div_done) begin
				seg_q <= FILL_W'(div_quot);
			end
			if (cfg_wr) begin
				for (int i = 0; i < MAX_STACKS; i++) begin
					fill_q[i] <= '0;
				end
			end else if (fill_we) begin
				fill_q[sidx] <= fill_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= kind_t'(kind);
			sn_q   <= stack_index;
			val_q  <= push_value;
		end
		base_q <= base_d;
		idx_q  <= idx_d;
		lcnt_q <= lcnt_d;
		st_q   <= st_d;
		last_q <= last_d;
		rd_q   <= rd_d;
	end

	pms_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_DEPTH)
	) u_words (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (val_q),
		.rdata (ram_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign strobe    = stb_q;
	assign status    = st_q;
	assign last      = last_q;
	assign data_word = rd_q ? ram_rdata : '0;

endmodule

/* sim/partitioned_multi_stack_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the partitioned multi-stack core with its own stack predictor.
module partitioned_multi_stack_core_test;
	import pms_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		status_t          status;
		logic [WORD_W-1:0] data;
		logic             last;
	} stack_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 start;
	logic                 busy;
	logic [KIND_W-1:0]    kind;
	logic [SN_W-1:0]      stack_index;
	logic signed [WORD_W-1:0] push_value;
	logic                 strobe;
	logic [STAT_W-1:0]    status;
	logic signed [WORD_W-1:0] data_word;
	logic                 last;

	// Predictor state: stored words, fill per stack and the two registers.
	logic [WORD_W-1:0] word_copy [MEM_DEPTH];
	logic [TW_W-1:0]   fill_copy [MAX_STACKS];
	logic [CNT_W-1:0]  count_reg;
	logic [TW_W-1:0]   words_reg;

	stack_result_t pending_results[$];
	stack_result_t head;

	int errors = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;
	int n_cmds = 0, n_push = 0, n_pop = 0, n_list = 0, n_writes = 0;
	int n_results = 0, n_overflow = 0, n_underflow = 0, n_bad = 0;

	partitioned_multi_stack_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.stack_index(stack_index),
		.push_value (push_value),
		.strobe     (strobe),
		.status     (status),
		.data_word  (data_word),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int live_stacks();
		int c;
		c = int'(count_reg);
		if (c < 1) c = 1;
		if (c > MAX_STACKS) c = MAX_STACKS;
		return c;
	endfunction

	function automatic int segment_words();
		int w;
		w = int'(words_reg);
		if (w < 1) w = 1;
		if (w > MEM_DEPTH) w = MEM_DEPTH;
		return w / live_stacks();
	endfunction

	task automatic add_expected(input status_t s, input logic [WORD_W-1:0] d, input logic l);
		stack_result_t r;
		r.status = s;
		r.data = d;
		r.last = l;
		pending_results.push_back(r);
	endtask

	// Works out the words that one accepted command produces and updates the stack copy.
	task automatic predict_stack_op(input kind_t k, input logic [SN_W-1:0] sn,
			input logic [WORD_W-1:0] val);
		int seg, base, fill;
		if (k == KIND_NONE) return;
		if (int'(sn) >= live_stacks()) begin
			n_bad++;
			add_expected(STAT_BAD, '0, 1'b1);
			return;
		end
		seg = segment_words();
		base = int'(sn) * seg;
		fill = int'(fill_copy[sn]);
		if (fill > seg) fill = seg;
		case (k)
			KIND_PUSH: begin
				if (fill >= seg || base + fill >= MEM_DEPTH) begin
					n_overflow++;
					add_expected(STAT_OVERFLOW, '0, 1'b1);
				end else begin
					word_copy[base + fill] = val;
					fill_copy[sn] = TW_W'(fill + 1);
					add_expected(STAT_PUSHED, '0, 1'b1);
				end
			end
			KIND_POP: begin
				if (fill == 0) begin
					n_underflow++;
					add_expected(STAT_UNDERFLOW, '0, 1'b1);
				end else begin
					fill_copy[sn] = TW_W'(fill - 1);
					add_expected(STAT_POPPED, word_copy[(base + fill - 1) % MEM_DEPTH], 1'b1);
				end
			end
			default: begin
				if (fill == 0) begin
					add_expected(STAT_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < fill; i++)
						add_expected(STAT_LISTED, word_copy[(base + i) % MEM_DEPTH],
							(i + 1 == fill));
				end
			end
		endcase
	endtask

	// Issues one command, holding start until the block takes it.
	task automatic send_command(input kind_t k, input logic [SN_W-1:0] sn,
			input logic [WORD_W-1:0] val);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		stack_index <= sn;
		push_value <= val;
		do @(posedge clk); while (busy);
		n_cmds++;
		if (k == KIND_PUSH) n_push++;
		if (k == KIND_POP) n_pop++;
		if (k == KIND_LIST) n_list++;
		predict_stack_op(k, sn, val);
	endtask

	// Lets every expected word arrive, then waits out any silent commands.
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write followed directly by a read back of the same register.
	task automatic write_register(input reg_idx_t r, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		n_writes++;
		if (r == REG_STACK_COUNT) count_reg = value[CNT_W-1:0];
		else words_reg = value[TW_W-1:0];
		for (int i = 0; i < MAX_STACKS; i++) fill_copy[i] = '0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = (r == REG_STACK_COUNT) ? PDATA_W'(count_reg) : PDATA_W'(words_reg);
		if (prdata !== readback) begin
			errors++;
			$display("%0t: register %s read back: expected %h, actual %h",
				$time, r.name(), readback, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_partition(input logic [CNT_W-1:0] c, input logic [TW_W-1:0] w);
		logic [PDATA_W-1:0] junk;
		settle();
		junk = $urandom();
		write_register(REG_STACK_COUNT, {junk[PDATA_W-1:CNT_W], c});
		junk = $urandom();
		write_register(REG_TOTAL_WORDS, {junk[PDATA_W-1:TW_W], w});
	endtask

	// One stack over all 64 words, as left by reset.
	task automatic test_default_partition();
		send_command(KIND_LIST, 4'd0, 32'h1234_5678);
		send_command(KIND_POP, 4'd0, 32'hFFFF_FFFF);
		send_command(KIND_PUSH, 4'd0, 32'h8000_0000);
		send_command(KIND_PUSH, 4'd0, 32'h7FFF_FFFF);
		send_command(KIND_PUSH, 4'd0, 32'hFFFF_FFFF);
		send_command(KIND_LIST, 4'd0, 32'h0);
		send_command(KIND_POP, 4'd0, 32'h0);
		send_command(KIND_NONE, 4'd0, 32'h5555_AAAA);
		send_command(KIND_PUSH, 4'd1, 32'hAAAA_5555);
		send_command(KIND_LIST, 4'd15, 32'h0);
	endtask

	// Ten stacks of two words: fill the top stack past its end.
	task automatic test_small_segments();
		set_partition(4'd10, 7'd20);
		send_command(KIND_PUSH, 4'd9, 32'hDEAD_BEEF);
		send_command(KIND_PUSH, 4'd9, 32'h0000_0001);
		send_command(KIND_PUSH, 4'd9, 32'hCAFE_F00D);
		send_command(KIND_LIST, 4'd9, 32'h0);
		send_command(KIND_POP, 4'd10, 32'h0);
	endtask

	// Fewer words than stacks leaves every segment without room.
	task automatic test_zero_length_segment();
		set_partition(4'd10, 7'd5);
		send_command(KIND_PUSH, 4'd3, 32'h1111_1111);
		send_command(KIND_POP, 4'd3, 32'h0);
		send_command(KIND_LIST, 4'd0, 32'h0);
	endtask

	// Register values outside the meaningful range are clamped by the block.
	task automatic test_clamped_registers();
		set_partition(4'd0, 7'd0);
		send_command(KIND_PUSH, 4'd0, 32'h0F0F_0F0F);
		send_command(KIND_PUSH, 4'd0, 32'hF0F0_F0F0);
		send_command(KIND_POP, 4'd0, 32'h0);
		send_command(KIND_PUSH, 4'd1, 32'h0);
		set_partition(4'd15, 7'd127);
		send_command(KIND_PUSH, 4'd9, 32'h8765_4321);
		send_command(KIND_LIST, 4'd9, 32'h0);
	endtask

	// Random traffic in two partitions; mostly legal stack operations with some noise.
	task automatic test_random_traffic(input int pct, input int n_items);
		int r, live, mode;
		logic [CNT_W-1:0] c;
		logic [TW_W-1:0] w;
		kind_t k;
		logic [SN_W-1:0] sn;
		for (int blk = 0; blk < 2; blk++) begin
			idle_pct = 0;
			c = CNT_W'($urandom_range(0, 15));
			count_reg = c;
			live = live_stacks();
			mode = $urandom_range(0, 3);
			case (mode)
				0: w = TW_W'($urandom_range(0, 127));
				1: w = TW_W'(live * $urandom_range(1, 3));
				2: w = TW_W'($urandom_range(0, live));
				default: w = 7'd64;
			endcase
			set_partition(c, w);
			idle_pct = pct;
			for (int i = 0; i < n_items / 2; i++) begin
				r = $urandom_range(0, 99);
				sn = SN_W'($urandom_range(0, live - 1));
				if (r < 45) k = KIND_PUSH;
				else if (r < 68) k = KIND_POP;
				else if (r < 84) k = KIND_LIST;
				else if (r < 94) begin
					k = kind_t'($urandom_range(0, 2));
					sn = SN_W'($urandom_range(live, 15));
				end else begin
					k = KIND_NONE;
					sn = SN_W'($urandom_range(0, 15));
				end
				send_command(k, sn, $urandom());
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			n_results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual status %0d data %h last %b",
					$time, status, data_word, last);
			end else begin
				head = pending_results.pop_front();
				if (status !== head.status || data_word !== head.data || last !== head.last) begin
					errors++;
					$display("%0t: expected status %0d data %h last %b, actual status %0d data %h last %b",
						$time, head.status, head.data, head.last, status, data_word, last);
				end
			end
		end
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (psel && penable)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired with %0d words outstanding",
				$time, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		kind <= KIND_PUSH;
		stack_index <= '0;
		push_value <= '0;
		count_reg = 4'd1;
		words_reg = 7'd64;
		for (int i = 0; i < MAX_STACKS; i++) fill_copy[i] = '0;
		for (int i = 0; i < MEM_DEPTH; i++) word_copy[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_partition();
		test_small_segments();
		test_zero_length_segment();
		test_clamped_registers();
		test_random_traffic(0, 88);
		test_random_traffic(62, 88);
		test_random_traffic(0, 88);
		test_random_traffic(28, 88);
		settle();

		$display("Covered %0d commands (%0d push, %0d pop, %0d display) across %0d register writes;",
			n_cmds, n_push, n_pop, n_list, n_writes);
		$display("checked %0d result words with %0d overflows, %0d underflows, %0d bad stacks.",
			n_results, n_overflow, n_underflow, n_bad);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
sv/pms_pkg.sv
sv/pms_ram.sv
sv/pms_seg_div.sv
sv/partitioned_multi_stack_core.sv
sim/partitioned_multi_stack_core_test.sv
